### design/bsd_pkg.sv
package bsd_pkg;

  // Coordinate width. Ports carry 32 bits; the low COORD_W bits are used (16..32).
  localparam int COORD_W = 32;
  // Number of axes in use (2 or 3). With 2, point_z, center_z and half_z are ignored.
  localparam int DIMS    = 3;

  localparam int PT_W      = 32;             // point and center field width
  localparam int HALF_W    = 31;             // half edge field width
  localparam int CFG_W     = 32;             // config write data width
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 32;

  localparam int OFF_W  = COORD_W + 1;       // point - center, and its magnitude
  localparam int D_W    = COORD_W + 2;       // |offset| - half, signed
  localparam int SQ_W   = 2 * OFF_W;         // square of a positive part
  localparam int SUM_W  = 2 * COORD_W + 2;   // sum of up to three squares, even width
  localparam int ROOT_W = SUM_W / 2;         // integer square root width
  localparam int REM_W  = ROOT_W + 3;        // partial remainder of the root recurrence
  localparam int RES_W  = COORD_W + 2;       // distance before clamping

  localparam logic signed [RES_W-1:0] SAT_HI =
    RES_W'((longint'(1) <<< (COORD_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO =
    RES_W'(-(longint'(1) <<< (COORD_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_HALF_X,
    REG_HALF_Y,
    REG_HALF_Z
  } cfg_reg_t;

endpackage

### design/box_signed_distance_unit.sv
// Signed distance from a query point to an axis-aligned box, signed Q16.16 in and
// out. The box center and half edges sit in six config registers (index 0..5:
// center x, y, z, half x, y, z; other indexes are ignored), all reset to zero; the
// user must write them only while no item is in flight, which the block itself does
// not enforce. Per axis d = |p - c| - h; the result is the floor square root of the
// summed squares of the positive d (outside the box), or the largest d (inside or on
// the box, zero or negative). It is clamped to the signed 32-bit range and
// out_saturated flags the clamp. The pipeline takes one item per cycle while not
// stalled and has three offset stages, one squaring stage, one summing stage, one
// stage per root bit (33 for the square root) and the output register. When the
// output item is stalled the whole pipeline holds, and in_stall follows.
module box_signed_distance_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bsd_pkg::PT_W-1:0]     in_point_x,
  input  logic signed [bsd_pkg::PT_W-1:0]     in_point_y,
  input  logic signed [bsd_pkg::PT_W-1:0]     in_point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bsd_pkg::OUT_W-1:0]    out_distance,
  output logic                                out_saturated,
  input  logic                                cfg_we,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsd_pkg::CFG_W-1:0]           cfg_wdata
);
  import bsd_pkg::*;

  // ---------------------------------------------------------------- config
  logic [PT_W-1:0]   ctr_r  [3];
  logic [HALF_W-1:0] half_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ctr_r[i]  <= '0;
        half_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: ctr_r[0]  <= cfg_wdata[PT_W-1:0];
        REG_CENTER_Y: ctr_r[1]  <= cfg_wdata[PT_W-1:0];
        REG_CENTER_Z: ctr_r[2]  <= cfg_wdata[PT_W-1:0];
        REG_HALF_X:   half_r[0] <= cfg_wdata[HALF_W-1:0];
        REG_HALF_Y:   half_r[1] <= cfg_wdata[HALF_W-1:0];
        REG_HALF_Z:   half_r[2] <= cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Single global advance: everything moves unless a finished item waits at the output.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic [PT_W-1:0] pt [3];
  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  // ---------------------------------------------------------------- per-axis front end
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [OFF_W-1:0] off_r [DIMS];   // stage 1: point - center
  logic        [OFF_W-1:0] abs_r [DIMS];   // stage 2: magnitude
  logic signed [D_W-1:0]   d_r   [DIMS];   // stage 3: magnitude - half edge
  logic        [SQ_W-1:0]  sq_r  [DIMS];   // stage 4: square of the positive part

  for (genvar a = 0; a < DIMS; a++) begin : g_axis
    logic signed [OFF_W-1:0] p_ext;
    logic signed [OFF_W-1:0] c_ext;
    logic signed [D_W-1:0]   h_ext;
    logic        [OFF_W-1:0] pos;
    logic        [SQ_W-1:0]  prod;
    logic                    d_pos;

    assign p_ext = OFF_W'(signed'(pt[a][COORD_W-1:0]));
    assign c_ext = OFF_W'(signed'(ctr_r[a][COORD_W-1:0]));
    assign h_ext = D_W'(half_r[a][COORD_W-2:0]);
    assign pos   = d_r[a][OFF_W-1:0];
    assign prod  = pos * pos;
    assign d_pos = !d_r[a][D_W-1] && (d_r[a] != '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        off_r[a] <= p_ext - c_ext;
        abs_r[a] <= off_r[a][OFF_W-1] ? OFF_W'(-off_r[a]) : OFF_W'(off_r[a]);
        d_r[a]   <= signed'(D_W'(abs_r[a])) - h_ext;
        sq_r[a]  <= d_pos ? prod : '0;
      end
    end
  end

  // largest d, formed alongside the squares
  logic signed [D_W-1:0] dmax_nxt;
  logic signed [D_W-1:0] dmax_r;

  always_comb begin
    dmax_nxt = d_r[0];
    for (int a = 1; a < DIMS; a++) begin
      if (d_r[a] > dmax_nxt) begin
        dmax_nxt = d_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmax_r <= dmax_nxt;
    end
  end

  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int a = 0; a < DIMS; a++) begin
      sum_nxt = sum_nxt + SUM_W'(sq_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------- square root pipeline
  // Digit recurrence, one root bit per stage. Entry 0 is loaded from the summing stage.
  logic                   vr_r  [ROOT_W+1];
  logic [SUM_W-1:0]       rad_r [ROOT_W+1];   // radicand, consumed two bits a stage
  logic [REM_W-1:0]       rem_r [ROOT_W+1];
  logic [ROOT_W-1:0]      rt_r  [ROOT_W+1];
  logic signed [D_W-1:0]  dm_r  [ROOT_W+1];   // largest d, carried alongside

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r[0] <= sum_nxt;
      rem_r[0] <= '0;
      rt_r[0]  <= '0;
      dm_r[0]  <= dmax_r;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] rt_nxt;

    assign cur     = {rem_r[k][REM_W-3:0], rad_r[k][SUM_W-1 -: 2]};
    assign trial   = {1'b0, rt_r[k], 2'b01};
    assign ge      = cur >= trial;
    assign rem_nxt = ge ? cur - trial : cur;
    assign rt_nxt  = {rt_r[k][ROOT_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k+1] <= {rad_r[k][SUM_W-3:0], 2'b00};
        rem_r[k+1] <= rem_nxt;
        rt_r[k+1]  <= rt_nxt;
        dm_r[k+1]  <= dm_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ROOT_W; k++) begin
        vr_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vr_r[0] <= v4_r;
      for (int k = 0; k < ROOT_W; k++) begin
        vr_r[k+1] <= vr_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- select, clamp, output
  // Outside the box the largest d is positive and the norm is the answer; otherwise
  // the norm is zero and the largest d is the answer.
  logic                    dm_pos;
  logic signed [RES_W-1:0] res;
  logic signed [RES_W-1:0] clamped;
  logic                    sat_nxt;
  logic signed [OUT_W-1:0] dist_r;
  logic                    sat_r;

  assign dm_pos = !dm_r[ROOT_W][D_W-1] && (dm_r[ROOT_W] != '0);
  assign res    = dm_pos ? signed'(RES_W'(rt_r[ROOT_W])) : RES_W'(dm_r[ROOT_W]);

  always_comb begin
    clamped = res;
    sat_nxt = 1'b0;
    if (res > SAT_HI) begin
      clamped = SAT_HI;
      sat_nxt = 1'b1;
    end else if (res < SAT_LO) begin
      clamped = SAT_LO;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vr_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= OUT_W'(clamped);
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = dist_r;
  assign out_saturated = sat_r;

  // ---------------------------------------------------------------- checks
  // a clamped item always sits on one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_distance == OUT_W'(SAT_HI)) || (out_distance == OUT_W'(SAT_LO)))
    else $error("saturated item not at a range limit");

  // inside or on the box no axis is positive, so the norm must come out zero
  a_inside_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    vr_r[ROOT_W] && !dm_pos |-> rt_r[ROOT_W] == '0)
    else $error("nonzero norm for a point inside the box");

  // a held output item freezes the pipeline tail as well
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && vr_r[ROOT_W] |=> vr_r[ROOT_W] && $stable(rt_r[ROOT_W]))
    else $error("pipeline moved while output was stalled");

endmodule

### dv/box_distance_checker.sv
`timescale 1ns / 100ps

module box_distance_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [bsd_pkg::PT_W-1:0]  in_point_x,
  input  logic signed [bsd_pkg::PT_W-1:0]  in_point_y,
  input  logic signed [bsd_pkg::PT_W-1:0]  in_point_z,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [bsd_pkg::OUT_W-1:0] out_distance,
  input  logic                             out_saturated,
  input  logic                             cfg_we,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsd_pkg::CFG_W-1:0]        cfg_wdata,
  output int                               errors,
  output int                               pending
);
  import bsd_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] distance;
    logic                    saturated;
  } box_distance_t;

  logic [CFG_W-1:0] box_center [3];
  logic [CFG_W-1:0] box_half [3];
  box_distance_t    distances_due [$];
  box_distance_t    oldest;

  function automatic box_distance_t predict_distance(input logic [PT_W-1:0] px, py, pz);
    logic [PT_W-1:0] pt [3];
    longint          p, c, h, d, dmax, total, hi_lim, lo_lim;
    logic [127:0]    sq_sum, root, trial;
    box_distance_t   r;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    sq_sum = '0;
    dmax = 0;
    for (int a = 0; a < DIMS; a++) begin
      p = longint'($signed(pt[a][COORD_W-1:0]));
      c = longint'($signed(box_center[a][COORD_W-1:0]));
      h = longint'(box_half[a][COORD_W-2:0]);
      d = ((p >= c) ? p - c : c - p) - h;
      if (a == 0 || d > dmax) begin
        dmax = d;
      end
      if (d > 0) begin
        sq_sum += 128'(d) * 128'(d);
      end
    end
    // floor square root, one bit at a time
    root = '0;
    for (int b = COORD_W + 1; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= sq_sum) begin
        root = trial;
      end
    end
    total = (dmax < 0 ? dmax : 0) + longint'(root[63:0]);
    hi_lim = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    r.saturated = 1'b0;
    if (total > hi_lim) begin
      total = hi_lim;
      r.saturated = 1'b1;
    end else if (total < lo_lim) begin
      total = lo_lim;
      r.saturated = 1'b1;
    end
    r.distance = OUT_W'(total);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_center[a] = '0;
        box_half[a] = '0;
      end
      distances_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (distances_due.size() == 0) begin
          $error("unexpected item: distance %0d saturated %0b", out_distance, out_saturated);
          errors++;
        end else begin
          oldest = distances_due.pop_front();
          if (out_distance !== oldest.distance) begin
            $error("distance: expected %0d, got %0d", oldest.distance, out_distance);
            errors++;
          end
          if (out_saturated !== oldest.saturated) begin
            $error("saturated: expected %0b, got %0b", oldest.saturated, out_saturated);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index) inside
          REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: box_center[cfg_index[1:0]] = cfg_wdata;
          REG_HALF_X, REG_HALF_Y, REG_HALF_Z:
            box_half[2'(cfg_index - REG_HALF_X)] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        distances_due.push_back(predict_distance(in_point_x, in_point_y, in_point_z));
      end
    end
    pending = distances_due.size();
  end

endmodule

### dv/tb_box_signed_distance_unit.sv
`timescale 1ns / 100ps

module tb_box_signed_distance_unit;
  import bsd_pkg::*;

  // Q16.16 landmarks
  localparam logic [PT_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [PT_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [PT_W-1:0] ONE       = 32'h0001_0000;
  localparam logic [PT_W-1:0] HALF_MAX  = 32'h7FFF_FFFF;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_HALF_Z + 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_HALF_Z + 2;

  // pipeline is 39 deep; a little margin for the final settle
  localparam int SETTLE_CYCLES = 45;
  // cycles with no handshake of any kind before declaring a hang
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_POINTS  = 134;
  localparam int BOX_PERIOD    = 45;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [PT_W-1:0]  in_point_x;
  logic signed [PT_W-1:0]  in_point_y;
  logic signed [PT_W-1:0]  in_point_z;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_distance;
  logic                    out_saturated;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  int errors;
  int pending;
  int quiet_cycles;
  int in_idle_pct;
  int out_stall_pct;
  int sender_idle [3]    = '{34, 64, 0};
  int receiver_stall [3] = '{64, 34, 0};

  // current box, kept here only to aim random points at it
  logic [PT_W-1:0] box_c [3];
  logic [PT_W-1:0] box_h [3];

  box_signed_distance_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance  (out_distance),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  box_distance_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_distance  (out_distance),
    .out_saturated (out_saturated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stall, redrawn every falling edge
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < out_stall_pct);
  end

  // hang detector: any accepted item or register write resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one point, with a random number of idle cycles first. Valid stays
  // high afterward so back-to-back items need no extra edge. Entered and left
  // at a falling edge.
  task automatic send_point(input logic [PT_W-1:0] x, y, z);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_point_x = x;
    in_point_y = y;
    in_point_z = z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every predicted item has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
  endtask

  // Program the whole box; pipeline must be empty. Spare indexes get junk
  // in between, which must not disturb anything.
  task automatic set_box(input logic [CFG_W-1:0] cx, cy, cz, hx, hy, hz);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_SPARE_LO, $urandom());
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_HALF_X, hx);
    cfg_write(REG_HALF_Y, hy);
    cfg_write(REG_HALF_Z, hz);
    cfg_write(REG_SPARE_HI, $urandom());
    cfg_we = 1'b0;
    box_c = '{cx, cy, cz};
    box_h = '{{1'b0, hx[30:0]}, {1'b0, hy[30:0]}, {1'b0, hz[30:0]}};
  endtask

  function automatic logic [CFG_W-1:0] pick_center();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return HALF_MAX;
      2:       return $urandom();      // top bit is dropped by the block
      default: return 32'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  // A coordinate around the box along one axis: mostly inside the box or within a
  // unit outside its faces, sometimes exactly on a face, sometimes anywhere.
  function automatic logic [PT_W-1:0] near_coord(input logic [PT_W-1:0] c, h);
    longint     span, offs;
    bit [63:0]  r;
    span = longint'(h) + longint'(ONE);
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: offs = $urandom_range(0, 1) ? longint'(h) : -longint'(h);
      default: offs = longint'(r % 64'(2 * span + 1)) - span;
    endcase
    return PT_W'(longint'($signed(c)) + offs);
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_point_x    = '0;
    in_point_y    = '0;
    in_point_z    = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_idle_pct   = sender_idle[0];
    out_stall_pct = receiver_stall[0];
    box_c         = '{'0, '0, '0};
    box_h         = '{'0, '0, '0};
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset box (center and half all zero): distance is the
    // plain vector length, with saturation at the corners of the range.
    send_point('0, '0, '0);
    send_point(ONE, '0, '0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(3 * ONE, 4 * ONE, '0);
    send_point(COORD_MAX, '0, '0);
    send_point(COORD_MIN, '0, '0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    wait_drained();

    // Small off-center box: inside, on a face, outside one face, past a corner.
    set_box(3 * ONE, -2 * ONE, ONE / 2, 3 * ONE, ONE, 5 * ONE);
    send_point(3 * ONE, -2 * ONE, ONE / 2);
    send_point(6 * ONE, -2 * ONE, ONE / 2);
    send_point(5 * ONE, -2 * ONE - ONE / 2, ONE / 2);
    send_point(10 * ONE, -2 * ONE, ONE / 2);
    send_point(7 * ONE, -4 * ONE, 6 * ONE + ONE / 2);
    send_point(-ONE, -2 * ONE, ONE / 2);
    wait_drained();

    // Extreme box: centers at the range ends, widest half edges (one written
    // with its unused top bit set). Deepest inside point, the far corner, zero and all-ones.
    set_box(COORD_MIN, COORD_MAX, COORD_MIN, HALF_MAX, HALF_MAX, 32'hFFFF_FFFF);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point('0, '0, '0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Random part: three idling patterns, new box every so often.
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct   = sender_idle[ph];
      out_stall_pct = receiver_stall[ph];
      for (int k = 0; k < PHASE_POINTS; k++) begin
        if (k % BOX_PERIOD == 0) begin
          wait_drained();
          set_box(pick_center(), pick_center(), pick_center(),
                  pick_half(), pick_half(), pick_half());
        end
        send_point(near_coord(box_c[0], box_h[0]),
                   near_coord(box_c[1], box_h[1]),
                   near_coord(box_c[2], box_h[2]));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
